>>> sv/lhsv_pkg.sv
// ----------------------------------------------------------------------------
// lhsv_pkg: shared types, constants and functions for linear_rgb_to_hsv
// Holds the field layout, the divider step and the gamma code generator
// that fills the per-channel lookup tables at elaboration.
// ----------------------------------------------------------------------------
package lhsv_pkg;

    // field layout
    localparam int CHANNEL_BITS   = 12;
    localparam int CODE_BITS      = 16;
    localparam int HUE_BITS       = 15;
    localparam int IN_DATA_BITS   = 40;
    localparam int OUT_DATA_BITS  = 48;
    localparam int RED_LSB        = 0;
    localparam int GREEN_LSB      = 12;
    localparam int BLUE_LSB       = 24;
    localparam int IN_PAD_BITS    = IN_DATA_BITS - 3 * CHANNEL_BITS;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - HUE_BITS - 2 * CODE_BITS;

    // hue arithmetic, in 1/64 degree
    localparam logic [CODE_BITS-1:0] HUE_FULL    = 16'd23040;
    localparam logic [CODE_BITS-1:0] HUE_QUO_MAX = 16'd7680;
    // sector offsets already include the -3840 shift that keeps the dividend positive
    localparam logic [CODE_BITS-1:0] OFF_RED_POS = 16'd61696;
    localparam logic [CODE_BITS-1:0] OFF_RED_NEG = 16'd19200;
    localparam logic [CODE_BITS-1:0] OFF_GREEN   = 16'd3840;
    localparam logic [CODE_BITS-1:0] OFF_BLUE    = 16'd11520;

    // restoring divider, 16 quotient bits, divisor below 2^17
    localparam int QUO_BITS       = 16;
    localparam int DEN_BITS       = 17;
    localparam int STEPS_PER_STG  = 2;
    localparam int DIV_STAGES     = QUO_BITS / STEPS_PER_STG;

    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [QUO_BITS-1:0] low;
        logic [DEN_BITS-1:0] den;
        logic [QUO_BITS-1:0] quo;
    } div_t;

    // gamma curve constants, exact rational form of the sRGB segments
    localparam int          BIG_BITS    = 352;
    localparam logic [63:0] CURVE_DEN   = 64'd2765577;
    localparam logic [63:0] CURVE_OFS   = 64'd144157;
    localparam logic [63:0] CURVE_STEP  = 64'd40;
    localparam logic [63:0] KNEE_NUM    = 64'd31308;
    localparam logic [63:0] KNEE_SCALE  = 64'd10000000;
    localparam logic [63:0] LIN_SLOPE2  = 64'd16934244;
    localparam logic [63:0] LIN_HALF    = 64'd10;
    localparam logic [63:0] LIN_DIV     = 64'd20;
    localparam int          SEARCH_ITER = 17;

    function automatic div_t div_step(input div_t s);
        div_t                r;
        logic [DEN_BITS:0]   t;
        logic [DEN_BITS+1:0] diff;
        t     = {s.rem, s.low[QUO_BITS-1]};
        diff  = {1'b0, t} - {2'b00, s.den};
        r.den = s.den;
        r.low = {s.low[QUO_BITS-2:0], 1'b0};
        if (!diff[DEN_BITS+1]) begin
            r.rem = diff[DEN_BITS-1:0];
            r.quo = {s.quo[QUO_BITS-2:0], 1'b1};
        end else begin
            r.rem = t[DEN_BITS-1:0];
            r.quo = {s.quo[QUO_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    // largest code c whose rounding threshold x reaches; power segment compares
    // x^5 * D^12 against (40c + 144157)^12 * M^5
    function automatic logic [CODE_BITS-1:0] gamma_code(input logic [15:0] x,
                                                         input int lin_bits);
        logic [BIG_BITS-1:0] lhs;
        logic [BIG_BITS-1:0] mpow;
        logic [BIG_BITS-1:0] a_big;
        logic [BIG_BITS-1:0] a2;
        logic [BIG_BITS-1:0] a4;
        logic [BIG_BITS-1:0] a8;
        logic [BIG_BITS-1:0] rhs;
        logic [63:0]         full;
        logic [63:0]         xw;
        logic [63:0]         mid_w;
        logic [31:0]         lo;
        logic [31:0]         hi;
        logic [31:0]         mid;
        logic                linear_seg;
        logic                reached;
        full       = (64'd1 << lin_bits) - 64'd1;
        xw         = {48'd0, x};
        linear_seg = (xw * KNEE_SCALE) <= (KNEE_NUM * full);
        lhs        = BIG_BITS'(1);
        for (int i = 0; i < 5; i++) begin
            lhs = lhs * BIG_BITS'(xw);
        end
        for (int i = 0; i < 12; i++) begin
            lhs = lhs * BIG_BITS'(CURVE_DEN);
        end
        mpow = BIG_BITS'(1);
        for (int i = 0; i < 5; i++) begin
            mpow = mpow * BIG_BITS'(full);
        end
        lo = 32'd0;
        hi = 32'd65535;
        for (int k = 0; k < SEARCH_ITER; k++) begin
            if (lo < hi) begin
                mid   = (lo + hi + 32'd1) >> 1;
                mid_w = {32'd0, mid};
                if (linear_seg) begin
                    reached = (LIN_DIV * full * mid_w) <= (LIN_SLOPE2 * xw + LIN_HALF * full);
                end else begin
                    a_big   = BIG_BITS'(CURVE_STEP * mid_w + CURVE_OFS);
                    a2      = a_big * a_big;
                    a4      = a2 * a2;
                    a8      = a4 * a4;
                    rhs     = a8 * a4 * mpow;
                    reached = lhs >= rhs;
                end
                if (reached) begin
                    lo = mid;
                end else begin
                    hi = mid - 32'd1;
                end
            end
        end
        return lo[CODE_BITS-1:0];
    endfunction

endpackage

>>> sv/lhsv_gamma_rom.sv
// ----------------------------------------------------------------------------
// lhsv_gamma_rom: sRGB gamma lookup table
// One read port with registered data; entries are 16-bit codes built at
// elaboration from the exact curve.
// ----------------------------------------------------------------------------
module lhsv_gamma_rom #(
    parameter int  LINEAR_BITS = 12,
    localparam int ADDR_BITS   = (LINEAR_BITS < lhsv_pkg::CHANNEL_BITS) ?
                                 LINEAR_BITS : lhsv_pkg::CHANNEL_BITS
) (
    input  logic                           aclk,
    input  logic                           rd_en,
    input  logic [ADDR_BITS-1:0]           rd_addr,
    output logic [lhsv_pkg::CODE_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [lhsv_pkg::CODE_BITS-1:0] rom_word [DEPTH];
    logic [lhsv_pkg::CODE_BITS-1:0] data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam logic [lhsv_pkg::CODE_BITS-1:0] CODE =
            lhsv_pkg::gamma_code(16'(i), LINEAR_BITS);
        assign rom_word[i] = CODE;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_reg <= rom_word[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

>>> sv/linear_rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// linear_rgb_to_hsv: linear RGB pixel to gamma-encoded HSV
// Channels go through the sRGB table, then max/min, and two pipelined
// restoring dividers give saturation and hue.
// ----------------------------------------------------------------------------
//  port group   dir   contents
//  s_t*         in    one linear pixel per item
//  m_t*         out   hue, saturation, brightness per item
//  cfg_*        in    dark_threshold write
//
//  one item per clock sustained while the output is taken
//  the depth comes from the two 16-bit dividers, two quotient bits per stage
//  a stage stalls only while it and every stage after it are full and the
//  output is not taken, so bubbles still fill behind a waiting result
//  reset clears all valid bits and sets dark_threshold to 1; tables are constant
// ----------------------------------------------------------------------------
module linear_rgb_to_hsv #(
    parameter int LINEAR_BITS = 12
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [lhsv_pkg::CODE_BITS-1:0]     cfg_wdata,   // dark_threshold
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // red_linear[11:0], green_linear[23:12], blue_linear[35:24], zero pad
    input  logic [lhsv_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hue[14:0], saturation[30:15], brightness[46:31], zero pad
    output logic [lhsv_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    localparam int ADDR_BITS  = (LINEAR_BITS < lhsv_pkg::CHANNEL_BITS) ?
                                LINEAR_BITS : lhsv_pkg::CHANNEL_BITS;
    localparam int DIV_STAGES = lhsv_pkg::DIV_STAGES;
    localparam int ST_INIT    = 3;
    localparam int NS         = ST_INIT + DIV_STAGES + 2;
    localparam int ST_OUT     = NS - 1;
    localparam int CW         = lhsv_pkg::CODE_BITS;
    localparam int DW         = lhsv_pkg::DEN_BITS;
    localparam logic [CW-1:0] DARK_RESET = 16'd1;

    typedef struct packed {
        logic [CW-1:0] v;
        logic [CW-1:0] off;
        logic          dark;
        logic          gray;
    } side_t;

    logic [NS-1:0]   valid_reg;
    logic [NS-1:0]   valid_in;
    logic [NS-1:0]   stage_en;
    logic [CW-1:0]   dark_threshold_reg;

    // ------------------------------------------------------------------ control
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign stage_en[k] = !(&valid_reg[NS-1:k]) || m_tready;
    end

    assign valid_in = {valid_reg[NS-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_threshold_reg <= DARK_RESET;
        end else if (cfg_wen) begin
            dark_threshold_reg <= cfg_wdata;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[ST_OUT];

    // ------------------------------------------------------------ stage 0: rom
    logic [CW-1:0] r0;
    logic [CW-1:0] g0;
    logic [CW-1:0] b0;

    lhsv_gamma_rom #(.LINEAR_BITS(LINEAR_BITS)) u_rom_red (
        .aclk    (aclk),
        .rd_en   (stage_en[0]),
        .rd_addr (s_tdata[lhsv_pkg::RED_LSB +: ADDR_BITS]),
        .rd_data (r0)
    );

    lhsv_gamma_rom #(.LINEAR_BITS(LINEAR_BITS)) u_rom_green (
        .aclk    (aclk),
        .rd_en   (stage_en[0]),
        .rd_addr (s_tdata[lhsv_pkg::GREEN_LSB +: ADDR_BITS]),
        .rd_data (g0)
    );

    lhsv_gamma_rom #(.LINEAR_BITS(LINEAR_BITS)) u_rom_blue (
        .aclk    (aclk),
        .rd_en   (stage_en[0]),
        .rd_addr (s_tdata[lhsv_pkg::BLUE_LSB +: ADDR_BITS]),
        .rd_data (b0)
    );

    // ------------------------------------------------------ stage 1: max / min
    logic          red_max;
    logic          green_max;
    logic [CW-1:0] v1_next, m1_next, p1_next, q1_next, off1_next, min_rg;
    logic [CW-1:0] v1_reg, m1_reg, p1_reg, q1_reg, off1_reg;

    always_comb begin
        red_max   = (r0 >= g0) && (r0 >= b0);
        green_max = !red_max && (g0 >= b0);
        min_rg    = (r0 < g0) ? r0 : g0;
        m1_next   = (min_rg < b0) ? min_rg : b0;
        // ties go red, then green
        if (red_max) begin
            v1_next   = r0;
            p1_next   = g0;
            q1_next   = b0;
            off1_next = (g0 < b0) ? lhsv_pkg::OFF_RED_NEG : lhsv_pkg::OFF_RED_POS;
        end else if (green_max) begin
            v1_next   = g0;
            p1_next   = b0;
            q1_next   = r0;
            off1_next = lhsv_pkg::OFF_GREEN;
        end else begin
            v1_next   = b0;
            p1_next   = r0;
            q1_next   = g0;
            off1_next = lhsv_pkg::OFF_BLUE;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            v1_reg   <= v1_next;
            m1_reg   <= m1_next;
            p1_reg   <= p1_next;
            q1_reg   <= q1_next;
            off1_reg <= off1_next;
        end
    end

    // ------------------------------------------------------- stage 2: spread
    logic [CW-1:0] d2_next;
    logic [CW+1:0] u2_wide;
    logic [CW-1:0] v2_reg, d2_reg, off2_reg;
    logic [DW-1:0] u2_reg;
    logic          dark2_reg, gray2_reg;

    always_comb begin
        d2_next = v1_reg - m1_reg;
        // difference shifted by d so it lies in [0, 2d]
        u2_wide = {2'b00, p1_reg} - {2'b00, q1_reg} + {2'b00, d2_next};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            v2_reg    <= v1_reg;
            d2_reg    <= d2_next;
            u2_reg    <= u2_wide[DW-1:0];
            off2_reg  <= off1_reg;
            dark2_reg <= (v1_reg == '0) || (v1_reg < dark_threshold_reg);
            gray2_reg <= (d2_next == '0);
        end
    end

    // ------------------------------------------------ stage 3: dividend set-up
    logic [29:0]          hnum;
    logic [32:0]          snum;
    lhsv_pkg::div_t       hdiv_init, sdiv_init;
    lhsv_pkg::div_t       hdiv_reg [DIV_STAGES+1];
    lhsv_pkg::div_t       sdiv_reg [DIV_STAGES+1];
    lhsv_pkg::div_t       hdiv_next [1:DIV_STAGES];
    lhsv_pkg::div_t       sdiv_next [1:DIV_STAGES];
    side_t                side_init;
    side_t                side_reg [DIV_STAGES+1];

    always_comb begin
        // 7680*u + d over 2d, and 131070*d + v over 2v
        hnum = (30'(u2_reg) << 13) - (30'(u2_reg) << 9) + 30'(d2_reg);
        snum = (33'(d2_reg) << 17) - (33'(d2_reg) << 1) + 33'(v2_reg);

        hdiv_init.rem = {3'b000, hnum[29:16]};
        hdiv_init.low = hnum[15:0];
        hdiv_init.den = {d2_reg, 1'b0};
        hdiv_init.quo = '0;

        sdiv_init.rem = snum[32:16];
        sdiv_init.low = snum[15:0];
        sdiv_init.den = {v2_reg, 1'b0};
        sdiv_init.quo = '0;

        side_init.v    = v2_reg;
        side_init.off  = off2_reg;
        side_init.dark = dark2_reg;
        side_init.gray = gray2_reg;
    end

    // -------------------------------------------------------- divider stages
    always_comb begin
        lhsv_pkg::div_t h_tmp;
        lhsv_pkg::div_t s_tmp;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            h_tmp = hdiv_reg[k-1];
            s_tmp = sdiv_reg[k-1];
            for (int j = 0; j < lhsv_pkg::STEPS_PER_STG; j++) begin
                h_tmp = lhsv_pkg::div_step(h_tmp);
                s_tmp = lhsv_pkg::div_step(s_tmp);
            end
            hdiv_next[k] = h_tmp;
            sdiv_next[k] = s_tmp;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_INIT]) begin
            hdiv_reg[0] <= hdiv_init;
            sdiv_reg[0] <= sdiv_init;
            side_reg[0] <= side_init;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (stage_en[ST_INIT+k]) begin
                hdiv_reg[k] <= hdiv_next[k];
                sdiv_reg[k] <= sdiv_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------- output stage
    logic [CW-1:0]                 hue_sum;
    logic [lhsv_pkg::HUE_BITS-1:0] hue_next, hue_reg;
    logic [CW-1:0]                 sat_next, sat_reg;
    logic [CW-1:0]                 bri_next, bri_reg;
    side_t                         side_last;

    assign side_last = side_reg[DIV_STAGES];

    always_comb begin
        hue_sum = side_last.off + hdiv_reg[DIV_STAGES].quo;
        if (side_last.dark) begin
            hue_next = '0;
            sat_next = '0;
            bri_next = '0;
        end else if (side_last.gray) begin
            hue_next = '0;
            sat_next = '0;
            bri_next = side_last.v;
        end else begin
            // full circle folds back to zero
            hue_next = (hue_sum >= lhsv_pkg::HUE_FULL) ? '0
                                                      : hue_sum[lhsv_pkg::HUE_BITS-1:0];
            sat_next = sdiv_reg[DIV_STAGES].quo;
            bri_next = side_last.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= bri_next;
        end
    end

    assign m_tdata = {{lhsv_pkg::OUT_PAD_BITS{1'b0}}, bri_reg, sat_reg, hue_reg};

    // ------------------------------------------------------------ assertions
    a_hue_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_OUT-1] && !side_last.gray
        |-> hdiv_reg[DIV_STAGES].rem < hdiv_reg[DIV_STAGES].den)
        else $error("hue divider remainder not below divisor");

    a_sat_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_OUT-1] && !side_last.dark
        |-> sdiv_reg[DIV_STAGES].rem < sdiv_reg[DIV_STAGES].den)
        else $error("saturation divider remainder not below divisor");

    a_hue_quo: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_OUT-1] && !side_last.gray
        |-> hdiv_reg[DIV_STAGES].quo <= lhsv_pkg::HUE_QUO_MAX)
        else $error("hue quotient out of range");

    a_gray_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (sat_reg == '0) |-> (hue_reg == '0))
        else $error("zero saturation with nonzero hue");

endmodule
